// ===== sv/daisy_chain_frame_command_node_macros.svh =====
// Assertion macros shared by the daisy-chain frame command node.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef DAISY_CHAIN_FRAME_COMMAND_NODE_MACROS_SVH
`define DAISY_CHAIN_FRAME_COMMAND_NODE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCFCN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCFCN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dcfcn_pkg.sv =====
// Shared types, codes and the LED time scaling function of the frame command node.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package dcfcn_pkg;

	localparam logic [7:0] CMD_C = 8'h43;
	localparam logic [7:0] CMD_R = 8'h52;
	localparam logic [7:0] CMD_L = 8'h4C;

	localparam logic [1:0] KIND_TX  = 2'd0;
	localparam logic [1:0] KIND_LED = 2'd1;
	localparam logic [1:0] KIND_OFF = 2'd2;
	localparam logic [1:0] KIND_ERR = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_DECODE,
		S_OFF,
		S_LED,
		S_FWD,
		S_SUM
	} state_t;

	typedef enum logic [2:0] {
		SEL_TX,
		SEL_SUM,
		SEL_LED,
		SEL_OFF,
		SEL_ERR
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		logic      set_node;
		logic      load_time;
		logic      fwd_clear;
		logic      out_load;
		logic      out_last;
		emit_sel_t sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_payload;
		logic sum_ok;
		logic cmd_c;
		logic cmd_r;
		logic cmd_l;
		logic id_match;
		logic fwd_end;
		logic out_free;
	} ctrl_sts_t;

	// Values up to ten count in steps of ten milliseconds, larger ones in steps of
	// a hundred above ten; the result is given in units of eight milliseconds.
	function automatic logic [11:0] scaled_time(input logic [7:0] v);
		logic [14:0] ms;
		if (v <= 8'd10) begin
			ms = {7'd0, v} * 15'd10;
		end else begin
			ms = {7'd0, v - 8'd10} * 15'd100;
		end
		return ms[14:3];
	endfunction

endpackage

`default_nettype wire

// ===== sv/dcfcn_ctrl.sv =====
// Controller state machine of the frame command node.
// Depends on dcfcn_pkg and the assertion macro header.
`default_nettype none
`include "daisy_chain_frame_command_node_macros.svh"

module dcfcn_ctrl
	import dcfcn_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.sel  = SEL_TX;
		unique case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && !sts.is_payload) begin
					state_d = sts.sum_ok ? S_DECODE : S_ERR;
				end
			end
			S_ERR: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.sel      = SEL_ERR;
					state_d      = S_IDLE;
				end
			end
			S_DECODE: begin
				cmd.fwd_clear = 1'b1;
				priority if (sts.cmd_c || sts.cmd_r) begin
					cmd.set_node = 1'b1;
					state_d      = sts.cmd_c ? S_OFF : S_FWD;
				end else if (sts.cmd_l && sts.id_match) begin
					cmd.load_time = 1'b1;
					state_d       = S_LED;
				end else if (sts.cmd_l) begin
					state_d = S_FWD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_OFF: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.sel      = SEL_OFF;
					state_d      = S_FWD;
				end
			end
			S_LED: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.sel      = SEL_LED;
					state_d      = S_IDLE;
				end
			end
			S_FWD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.sel      = SEL_TX;
					if (sts.fwd_end) begin
						state_d = S_SUM;
					end
				end
			end
			S_SUM: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					cmd.sel      = SEL_SUM;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`DCFCN_ASSERT_NEXT(a_last_returns_idle, cmd.out_load && cmd.out_last,
		state_q == S_IDLE, "Final beat of a frame did not return the controller to idle.")
	`DCFCN_ASSERT_NEXT(a_bad_sum_reports, cmd.accept && !sts.is_payload && !sts.sum_ok,
		state_q == S_ERR, "A bad checksum did not lead to an error report.")
	`DCFCN_ASSERT_NOW(a_load_needs_slot, cmd.out_load, sts.out_free,
		"Output register loaded while a result still waits.")

endmodule

`default_nettype wire

// ===== sv/dcfcn_dp.sv =====
// Datapath of the frame command node: frame store, checksums, node id and output register.
// Depends on dcfcn_pkg and the assertion macro header.
`default_nettype none
`include "daisy_chain_frame_command_node_macros.svh"

module dcfcn_dp
	import dcfcn_pkg::*;
#(
	parameter int FRAME_LEN = 6
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic [7:0]   rx_byte,
	input  wire ctrl_cmd_t    cmd,
	output ctrl_sts_t         sts,
	output logic [1:0]        kind,
	output logic [7:0]        tx_byte,
	output logic [7:0]        brightness,
	output logic [11:0]       on_time,
	output logic [11:0]       fade_time,
	output logic              last,
	output logic              out_valid,
	input  wire logic         out_ready
);

	localparam int PAYLOAD_LEN = FRAME_LEN - 1;
	localparam int STORE_LEN   = (PAYLOAD_LEN > 5) ? PAYLOAD_LEN : 5;
	localparam int POS_W       = $clog2(PAYLOAD_LEN + 1);
	localparam int IDX_W       = $clog2(STORE_LEN);

	logic [7:0]       fb_q [STORE_LEN];
	logic [POS_W-1:0] pos_q;
	logic [7:0]       run_xor_q;
	logic [7:0]       node_id_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic [7:0]       fwd_xor_q;
	logic [11:0]      on_time_q;
	logic [11:0]      fade_time_q;
	logic [1:0]       kind_q;
	logic [7:0]       tx_byte_q;
	logic [7:0]       brightness_q;
	logic [11:0]      on_out_q;
	logic [11:0]      fade_out_q;
	logic             last_q;
	logic             out_valid_q;

	logic             is_payload;
	logic [7:0]       b0;
	logic [7:0]       b1;
	logic [7:0]       b2;
	logic [7:0]       b3;
	logic [7:0]       b4;
	logic [7:0]       fwd_byte;
	logic [1:0]       kind_d;
	logic [7:0]       tx_byte_d;
	logic [7:0]       brightness_d;
	logic [11:0]      on_out_d;
	logic [11:0]      fade_out_d;

	// A frame shorter than five payload bytes has no byte four, which reads as zero.
	assign b0         = fb_q[0];
	assign b1         = fb_q[1];
	assign b2         = fb_q[2];
	assign b3         = fb_q[3];
	assign b4         = (PAYLOAD_LEN > 4) ? fb_q[4] : 8'd0;
	assign fwd_byte   = fb_q[fwd_idx_q];
	assign is_payload = pos_q < POS_W'(PAYLOAD_LEN);

	always_comb begin
		sts            = '0;
		sts.is_payload = is_payload;
		sts.sum_ok     = rx_byte == run_xor_q;
		sts.cmd_c      = b0 == CMD_C;
		sts.cmd_r      = b0 == CMD_R;
		sts.cmd_l      = b0 == CMD_L;
		sts.id_match   = b1 == node_id_q;
		sts.fwd_end    = fwd_idx_q == IDX_W'(PAYLOAD_LEN - 1);
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		kind_d       = KIND_TX;
		tx_byte_d    = '0;
		brightness_d = '0;
		on_out_d     = '0;
		fade_out_d   = '0;
		unique case (cmd.sel)
			SEL_TX: begin
				tx_byte_d = fwd_byte;
			end
			SEL_SUM: begin
				tx_byte_d = fwd_xor_q;
			end
			SEL_LED: begin
				kind_d       = KIND_LED;
				brightness_d = b2;
				on_out_d     = on_time_q;
				fade_out_d   = fade_time_q;
			end
			SEL_OFF: begin
				kind_d = KIND_OFF;
			end
			SEL_ERR: begin
				kind_d = KIND_ERR;
			end
			default: begin
				kind_d = KIND_TX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			run_xor_q   <= '0;
			node_id_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				if (is_payload) begin
					pos_q     <= pos_q + POS_W'(1);
					run_xor_q <= run_xor_q ^ rx_byte;
				end else begin
					pos_q     <= '0;
					run_xor_q <= '0;
				end
			end
			if (cmd.set_node) begin
				node_id_q <= b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < STORE_LEN; i++) begin
			if (cmd.accept && is_payload && pos_q == POS_W'(i)) begin
				fb_q[i] <= rx_byte;
			end
		end
		if (cmd.set_node) begin
			fb_q[1] <= b1 + 8'd1;
		end
		if (cmd.load_time) begin
			on_time_q   <= scaled_time(b3);
			fade_time_q <= scaled_time(b4);
		end
		if (cmd.fwd_clear) begin
			fwd_idx_q <= '0;
			fwd_xor_q <= '0;
		end else if (cmd.out_load && cmd.sel == SEL_TX) begin
			fwd_idx_q <= fwd_idx_q + IDX_W'(1);
			fwd_xor_q <= fwd_xor_q ^ fwd_byte;
		end
		if (cmd.out_load) begin
			kind_q       <= kind_d;
			tx_byte_q    <= tx_byte_d;
			brightness_q <= brightness_d;
			on_out_q     <= on_out_d;
			fade_out_q   <= fade_out_d;
			last_q       <= cmd.out_last;
		end
	end

	assign kind       = kind_q;
	assign tx_byte    = tx_byte_q;
	assign brightness = brightness_q;
	assign on_time    = on_out_q;
	assign fade_time  = fade_out_q;
	assign last       = last_q;
	assign out_valid  = out_valid_q;

	`DCFCN_ASSERT_NEXT(a_frame_end_clears, cmd.accept && !is_payload,
		pos_q == '0 && run_xor_q == '0, "Frame position or running checksum not cleared.")
	`DCFCN_ASSERT_NEXT(a_load_shows_beat, cmd.out_load, out_valid_q,
		"A loaded result beat is not offered downstream.")

endmodule

`default_nettype wire

// ===== sv/daisy_chain_frame_command_node.sv =====
// Receives bytes from the upstream link one beat at a time and collects frames of FRAME_LEN
// bytes, the last being the XOR of the others. A payload byte is taken once offered. The
// checksum byte is followed by a decode state and then up to FRAME_LEN + 1 result beats,
// and the next byte is held off until the final beat is loaded into the single output
// register, which issues one beat a cycle while downstream keeps up. The next byte is taken
// while the final result beat still waits downstream. A frame with a bad checksum gives one
// error beat. The frame store has no reset.
`default_nettype none

module daisy_chain_frame_command_node
	import dcfcn_pkg::*;
#(
	parameter int FRAME_LEN = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic [1:0]       kind,
	output logic [7:0]       tx_byte,
	output logic [7:0]       brightness,
	output logic [11:0]      on_time,
	output logic [11:0]      fade_time,
	output logic             last,
	output logic             out_valid,
	input  wire logic        out_ready
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	dcfcn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dcfcn_dp #(
		.FRAME_LEN (FRAME_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.brightness (brightness),
		.on_time    (on_time),
		.fade_time  (fade_time),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

`default_nettype wire

// ===== verif/daisy_chain_frame_command_node_tb.sv =====
// Self-checking testbench for the daisy-chain frame command node: a directed table, then
// random frames under several idling phases, each result beat checked against a predictor.
// Depends on dcfcn_pkg and daisy_chain_frame_command_node only.
module daisy_chain_frame_command_node_tb
	import dcfcn_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN   = 6;
	localparam int PAYLOAD_LEN = FRAME_LEN - 1;
	localparam int STORE_LEN   = (PAYLOAD_LEN > 5) ? PAYLOAD_LEN : 5;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = FRAME_LEN + 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int FRAMES_PER_PHASE = 10;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [7:0]  brightness;
		logic [11:0] on_time;
		logic [11:0] fade_time;
		logic        last;
	} node_beat_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		logic       gives_beat;
		node_beat_t beat;
	} stim_row_t;

	localparam node_beat_t NO_BEAT  = '0;
	localparam node_beat_t ERR_BEAT = '{KIND_ERR, 8'h00, 8'h00, 12'd0, 12'd0, 1'b1};
	localparam node_beat_t LED_TOP  = '{KIND_LED, 8'h00, 8'hFF, 12'd3062, 12'd12, 1'b1};

	localparam stim_row_t DIRECTED [24] = '{
		'{8'h4C, 1'b1, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{8'h00, 1'b1, 1'b1, ERR_BEAT},
		'{8'h43, 1'b0, 1'b0, NO_BEAT},
		'{8'hFF, 1'b0, 1'b0, NO_BEAT},
		'{8'h12, 1'b0, 1'b0, NO_BEAT},
		'{8'h34, 1'b0, 1'b0, NO_BEAT},
		'{8'h56, 1'b0, 1'b0, NO_BEAT},
		'{8'hCC, 1'b0, 1'b0, NO_BEAT},
		'{8'h4C, 1'b1, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{8'hFF, 1'b1, 1'b0, NO_BEAT},
		'{8'h0A, 1'b1, 1'b0, NO_BEAT},
		'{8'hB9, 1'b1, 1'b1, LED_TOP},
		'{8'h52, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, NO_BEAT},
		'{8'h00, 1'b0, 1'b0, NO_BEAT},
		'{8'h52, 1'b0, 1'b0, NO_BEAT}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic [7:0]  brightness;
	logic [11:0] on_time;
	logic [11:0] fade_time;
	logic        last;
	logic        out_valid;
	logic        out_ready = 1'b0;

	node_beat_t  awaited_beats [$];
	logic [7:0]  frame_store [STORE_LEN];
	int unsigned frame_pos = 0;
	logic [7:0]  frame_xor = 8'h00;
	logic [7:0]  node_id = 8'h00;

	int unsigned mismatches = 0;
	int unsigned beat_index = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_req = 1'b0;

	daisy_chain_frame_command_node #(
		.FRAME_LEN(FRAME_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx_byte),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.tx_byte(tx_byte),
		.brightness(brightness),
		.on_time(on_time),
		.fade_time(fade_time),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [11:0] led_time(input logic [7:0] v);
		int unsigned ms;
		if (v <= 8'd10) begin
			ms = v * 10;
		end else begin
			ms = (v - 10) * 100;
		end
		return 12'(ms / 8);
	endfunction

	function automatic node_beat_t make_beat(input logic [1:0] k, input logic [7:0] tx,
			input logic [7:0] br, input logic [11:0] on_t, input logic [11:0] fade_t);
		node_beat_t b;
		b = '{k, tx, br, on_t, fade_t, 1'b0};
		return b;
	endfunction

	function automatic void predict_node_beats(input logic [7:0] b, input bit keep);
		node_beat_t beats [$];
		logic [7:0] sum;
		logic [7:0] cmd;
		if (frame_pos < PAYLOAD_LEN) begin
			frame_xor ^= b;
			if (frame_pos < STORE_LEN) begin
				frame_store[frame_pos] = b;
			end
			frame_pos++;
			return;
		end
		sum = frame_xor;
		frame_xor = 8'h00;
		frame_pos = 0;
		cmd = frame_store[0];
		if (b != sum) begin
			beats.push_back(make_beat(KIND_ERR, 8'h00, 8'h00, 12'd0, 12'd0));
		end else if (cmd == CMD_L && frame_store[1] == node_id) begin
			beats.push_back(make_beat(KIND_LED, 8'h00, frame_store[2],
				led_time(frame_store[3]), led_time(frame_store[4])));
		end else if (cmd == CMD_C || cmd == CMD_R || cmd == CMD_L) begin
			if (cmd == CMD_C) begin
				beats.push_back(make_beat(KIND_OFF, 8'h00, 8'h00, 12'd0, 12'd0));
			end
			if (cmd != CMD_L) begin
				node_id = frame_store[1];
				frame_store[1] = node_id + 8'd1;
			end
			sum = 8'h00;
			for (int i = 0; i < PAYLOAD_LEN && i < STORE_LEN; i++) begin
				sum ^= frame_store[i];
				beats.push_back(make_beat(KIND_TX, frame_store[i], 8'h00, 12'd0, 12'd0));
			end
			beats.push_back(make_beat(KIND_TX, sum, 8'h00, 12'd0, 12'd0));
		end
		if (beats.size() != 0) begin
			beats[beats.size() - 1].last = 1'b1;
		end
		if (keep) begin
			foreach (beats[i]) awaited_beats.push_back(beats[i]);
		end
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_REPORTS) begin
			$display("MISMATCH beat %0d at cycle %0d: %s", beat_index, cycle_count, msg);
		end
		mismatches++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit keep);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		rx_byte <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_node_beats(b, keep);
	endtask

	task automatic send_random_frame();
		logic [7:0]  body [PAYLOAD_LEN];
		logic [7:0]  sum;
		int unsigned pick;
		int unsigned damage;
		sum = 8'h00;
		pick = $urandom_range(99);
		damage = $urandom_range(99);
		foreach (body[i]) body[i] = 8'($urandom);
		if (damage >= 10) begin
			if (pick < 25) begin
				body[0] = CMD_R;
			end else if (pick < 45) begin
				body[0] = CMD_C;
			end else if (pick < 85) begin
				body[0] = CMD_L;
				if ($urandom_range(1) == 0) body[1] = node_id;
			end else begin
				do body[0] = 8'($urandom); while (body[0] inside {CMD_C, CMD_R, CMD_L});
			end
			if ($urandom_range(2) == 0) body[3] = 8'($urandom_range(12));
			if ($urandom_range(2) == 0) body[4] = 8'($urandom_range(12));
		end
		foreach (body[i]) begin
			sum ^= body[i];
			send_byte(body[i], 1'b1);
		end
		if (damage < 10) begin
			sum = 8'($urandom);
		end else if (damage < 20) begin
			sum ^= 8'(1 << $urandom_range(7));
		end
		send_byte(sum, 1'b1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		node_beat_t got;
		node_beat_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got = {kind, tx_byte, brightness, on_time, fade_time, last};
				if (awaited_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected beat kind %0d tx_byte %0d",
						got.kind, got.tx_byte));
				end else begin
					want = awaited_beats.pop_front();
					check_field("kind", got.kind, want.kind);
					check_field("tx_byte", got.tx_byte, want.tx_byte);
					check_field("brightness", got.brightness, want.brightness);
					check_field("on_time", got.on_time, want.on_time);
					check_field("fade_time", got.fade_time, want.fade_time);
					check_field("last", got.last, want.last);
				end
				beat_index++;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("daisy_chain_frame_command_node_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		foreach (frame_store[i]) frame_store[i] = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (DIRECTED[i]) begin
			send_byte(DIRECTED[i].rx, !DIRECTED[i].typed);
			if (DIRECTED[i].typed && DIRECTED[i].gives_beat) begin
				awaited_beats.push_back(DIRECTED[i].beat);
			end
		end
		wait_drained();

		// Downstream blocked for a long stretch while frames keep arriving.
		hold_req = 1'b1;
		repeat (FRAMES_PER_PHASE) send_random_frame();
		wait_drained();

		for (int phase = 1; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1) ? 88 : (phase == 3) ? 20 : 0;
			recv_stall_pct = (phase == 2) ? 88 : (phase == 3) ? 20 : 0;
			repeat (FRAMES_PER_PHASE) send_random_frame();
			wait_drained();
		end

		if (mismatches == 0 && awaited_beats.size() == 0) begin
			$display("daisy_chain_frame_command_node_tb OK");
		end else begin
			$display("daisy_chain_frame_command_node_tb NOT OK");
		end
		$finish;
	end

endmodule
